// ===== src/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared sizes, codes, command and status types and helper functions for the
// FIFO queue with key search.
// ----------------------------------------------------------------------------
package fqs_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 32;
   localparam int AGE_W    = 4;

   localparam logic [OP_W-1:0] OP_ENQ    = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQ    = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_OK,
      RES_EMPTY,
      RES_FULL,
      RES_NOTFOUND,
      RES_DEQ,
      RES_FOUND
   } res_sel_type;

   typedef struct packed {
      logic        take;
      logic        enq_write;
      logic        read_oldest;
      logic        scan_start;
      logic        scan_step;
      res_sel_type result;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic hit;
      logic scan_last;
   } dp_stat_type;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i == IDX_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = i + IDX_W'(1);
      end
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i == '0) begin
         r = IDX_W'(DEPTH - 1);
      end else begin
         r = i - IDX_W'(1);
      end
      return r;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] fit_data(input logic [VALUE_W-1:0] v);
      logic [DATA_WIDTH+VALUE_W-1:0] t;
      t = {{DATA_WIDTH{1'b0}}, v};
      return t[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] data_to_value(input logic [DATA_WIDTH-1:0] d);
      logic [DATA_WIDTH+VALUE_W-1:0] t;
      t = {{VALUE_W{1'b0}}, d};
      return t[VALUE_W-1:0];
   endfunction

endpackage

// ===== src/fqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fqs_ctrl
// Command sequencer: takes one item at a time, steps dequeue and search
// through the datapath and owns the result valid flag.
// ----------------------------------------------------------------------------
module fqs_ctrl
   import fqs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [OP_W-1:0] req_opcode,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  dp_stat_type     stat,
   output dp_cmd_type      cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DEQ,
      S_SEARCH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.take        = 1'b0;
      cmd.enq_write   = 1'b0;
      cmd.read_oldest = 1'b0;
      cmd.scan_start  = 1'b0;
      cmd.scan_step   = 1'b0;
      cmd.result      = RES_NONE;
      state_in        = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.take = 1'b1;
               unique case (req_opcode)
                  OP_ENQ: begin
                     if (stat.full) begin
                        cmd.result = RES_FULL;
                     end else begin
                        cmd.enq_write = 1'b1;
                        cmd.result    = RES_OK;
                     end
                  end
                  OP_DEQ: begin
                     if (stat.empty) begin
                        cmd.result = RES_EMPTY;
                     end else begin
                        cmd.read_oldest = 1'b1;
                        state_in        = S_DEQ;
                     end
                  end
                  OP_SEARCH: begin
                     if (stat.empty) begin
                        cmd.result = RES_NOTFOUND;
                     end else begin
                        cmd.scan_start = 1'b1;
                        state_in       = S_SEARCH;
                     end
                  end
                  default: begin
                     cmd.result = RES_OK;
                  end
               endcase
            end
         end
         S_DEQ: begin
            cmd.result = RES_DEQ;
            state_in   = S_IDLE;
         end
         S_SEARCH: begin
            priority if (stat.hit) begin
               cmd.result = RES_FOUND;
               state_in   = S_IDLE;
            end else if (stat.scan_last) begin
               cmd.result = RES_NOTFOUND;
               state_in   = S_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result != RES_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/fqs_datapath.sv =====
// ----------------------------------------------------------------------------
// fqs_datapath
// Entry memory, ring pointers, entry count, search scan registers and the
// result register.
// ----------------------------------------------------------------------------
module fqs_datapath
   import fqs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_stat_type                stat,
   input  logic signed [VALUE_W-1:0]  req_enq_value,
   input  logic signed [VALUE_W-1:0]  req_search_key,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_out_value,
   output logic [AGE_W-1:0]           rsp_match_age
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [IDX_W-1:0]      oldest_ff, oldest_in;
   logic [IDX_W-1:0]      next_free_ff, next_free_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      scan_addr_ff, scan_addr_in;
   logic [IDX_W-1:0]      scan_age_ff, scan_age_in;
   logic [DATA_WIDTH-1:0] key_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W+AGE_W-1:0] age_ext;

   logic [STATUS_W-1:0]   status_ff;
   logic [VALUE_W-1:0]    value_ff;
   logic [AGE_W-1:0]      age_ff;

   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.empty     = (count_ff == '0);
   assign stat.hit       = (rd_data_ff == key_ff);
   assign stat.scan_last = ((CNT_W'(scan_age_ff) + CNT_W'(1)) == count_ff);

   assign age_ext = {{AGE_W{1'b0}}, scan_age_ff};

   always_comb begin
      priority if (cmd.read_oldest) begin
         rd_addr = oldest_ff;
      end else if (cmd.scan_start) begin
         rd_addr = idx_prev(next_free_ff);
      end else begin
         rd_addr = idx_prev(scan_addr_ff);
      end
   end

   always_comb begin
      oldest_in    = oldest_ff;
      next_free_in = next_free_ff;
      count_in     = count_ff;
      scan_addr_in = scan_addr_ff;
      scan_age_in  = scan_age_ff;
      if (cmd.enq_write) begin
         next_free_in = idx_next(next_free_ff);
         count_in     = count_ff + CNT_W'(1);
      end
      if (cmd.result == RES_DEQ) begin
         oldest_in = idx_next(oldest_ff);
         count_in  = count_ff - CNT_W'(1);
      end
      if (cmd.scan_start) begin
         scan_addr_in = rd_addr;
         scan_age_in  = '0;
      end else if (cmd.scan_step) begin
         scan_addr_in = rd_addr;
         scan_age_in  = scan_age_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.enq_write) begin
         mem[next_free_ff] <= fit_data(req_enq_value);
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         next_free_ff <= '0;
         count_ff     <= '0;
      end else begin
         oldest_ff    <= oldest_in;
         next_free_ff <= next_free_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      scan_age_ff  <= scan_age_in;
      if (cmd.take) begin
         key_ff <= fit_data(req_search_key);
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.result)
         RES_NONE: begin
         end
         RES_OK: begin
            status_ff <= ST_OK;
            value_ff  <= '0;
            age_ff    <= '0;
         end
         RES_EMPTY: begin
            status_ff <= ST_EMPTY;
            value_ff  <= '0;
            age_ff    <= '0;
         end
         RES_FULL: begin
            status_ff <= ST_FULL;
            value_ff  <= '0;
            age_ff    <= '0;
         end
         RES_NOTFOUND: begin
            status_ff <= ST_NOTFOUND;
            value_ff  <= '0;
            age_ff    <= '0;
         end
         RES_DEQ: begin
            status_ff <= ST_OK;
            value_ff  <= data_to_value(rd_data_ff);
            age_ff    <= '0;
         end
         RES_FOUND: begin
            status_ff <= ST_OK;
            value_ff  <= '0;
            age_ff    <= age_ext[AGE_W-1:0];
         end
         default: begin
         end
      endcase
   end

   assign rsp_status    = status_ff;
   assign rsp_out_value = value_ff;
   assign rsp_match_age = age_ff;

endmodule

// ===== src/fifo_queue_with_search_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search_unit
// Bounded FIFO of data words with enqueue, dequeue and newest-first key search.
// ----------------------------------------------------------------------------
// One item is processed at a time; the next item is accepted once the result
// register is free or being taken. Enqueue, refused commands (full, empty,
// search on an empty queue) and the unused opcode go straight to the result
// register. Dequeue reads the oldest entry, then stores it there. Search ends
// at the first match or after the oldest entry: the entry memory has one
// registered read port and the scan reads one entry per cycle, newest first.
module fifo_queue_with_search_unit
   import fqs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_opcode,
   input  logic signed [VALUE_W-1:0] req_enq_value,
   input  logic signed [VALUE_W-1:0] req_search_key,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic [AGE_W-1:0]          rsp_match_age
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   fqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fqs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_enq_value  (req_enq_value),
      .req_search_key (req_search_key),
      .rsp_status     (rsp_status),
      .rsp_out_value  (rsp_out_value),
      .rsp_match_age  (rsp_match_age)
   );

endmodule

// ===== test/fifo_queue_with_search_unit_tb.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search_unit_tb
// Self-checking bench for the FIFO queue with key search. Commands (enqueue,
// dequeue, search, unused opcode) go out over a valid/ready channel with random
// gaps. A local queue model predicts each response, and the monitor checks
// every response field against the oldest prediction. The run has a directed
// opening through the full, empty and wrap cases, then three random phases
// with different idle mixes and one long response stall.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_unit_tb;
   import fqs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int STALL_AT     = 600;
   localparam int STALL_CYCLES = 150;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] word;
      logic [VALUE_W-1:0] key;
   } command_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
      logic [AGE_W-1:0]    age;
   } outcome_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OP_W-1:0]           req_opcode = '0;
   logic signed [VALUE_W-1:0] req_enq_value = '0;
   logic signed [VALUE_W-1:0] req_search_key = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic [AGE_W-1:0]          rsp_match_age;

   command_type cmd_backlog[$];
   outcome_type pending_outcomes[$];
   logic [VALUE_W-1:0] plan_words[$];

   logic [DATA_WIDTH-1:0] model_word [DEPTH];
   int  model_oldest = 0;
   int  model_free   = 0;
   int  model_count  = 0;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  cmds_taken = 0;
   int  mismatch_cnt = 0;
   int  stall_left = 0;
   logic stall_done = 1'b0;

   fifo_queue_with_search_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_enq_value  (req_enq_value),
      .req_search_key (req_search_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_value  (rsp_out_value),
      .rsp_match_age  (rsp_match_age)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic outcome_type run_queue_command(command_type c);
      outcome_type r;
      logic [DATA_WIDTH-1:0] k;
      int idx;
      bit hit;
      r.status = ST_OK;
      r.value  = '0;
      r.age    = '0;
      case (c.op)
         OP_ENQ: begin
            if (model_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               model_word[model_free] = DATA_WIDTH'(c.word);
               model_free  = (model_free + 1) % DEPTH;
               model_count = model_count + 1;
            end
         end
         OP_DEQ: begin
            if (model_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.value      = VALUE_W'(model_word[model_oldest]);
               model_oldest = (model_oldest + 1) % DEPTH;
               model_count  = model_count - 1;
            end
         end
         OP_SEARCH: begin
            k   = DATA_WIDTH'(c.key);
            hit = 1'b0;
            for (int a = 0; a < model_count && !hit; a++) begin
               idx = (model_free + DEPTH - 1 - a) % DEPTH;
               if (model_word[idx] == k) begin
                  hit   = 1'b1;
                  r.age = AGE_W'(a);
               end
            end
            if (!hit) begin
               r.status = ST_NOTFOUND;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic note_mismatch(string what, logic [VALUE_W-1:0] got,
                                logic [VALUE_W-1:0] want);
      mismatch_cnt++;
      $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
   endtask

   always @(posedge clock) begin : drive
      command_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            nxt.op   = req_opcode;
            nxt.word = req_enq_value;
            nxt.key  = req_search_key;
            pending_outcomes.push_back(run_queue_command(nxt));
            cmds_taken <= cmds_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = cmd_backlog.pop_front();
               req_valid      <= 1'b1;
               req_opcode     <= nxt.op;
               req_enq_value  <= nxt.word;
               req_search_key <= nxt.key;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         stall_done <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!stall_done && cmds_taken >= STALL_AT) begin
         stall_left <= STALL_CYCLES;
         stall_done <= 1'b1;
      end
   end

   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               note_mismatch("unexpected item", VALUE_W'(rsp_status), '0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status) begin
                  note_mismatch("status", VALUE_W'(rsp_status), VALUE_W'(want.status));
               end
               if (rsp_out_value !== want.value) begin
                  note_mismatch("out_value", rsp_out_value, want.value);
               end
               if (rsp_match_age !== want.age) begin
                  note_mismatch("match_age", VALUE_W'(rsp_match_age), VALUE_W'(want.age));
               end
            end
         end
         rsp_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic add_cmd(logic [OP_W-1:0] op, logic [VALUE_W-1:0] word,
                          logic [VALUE_W-1:0] key);
      command_type c;
      c.op   = op;
      c.word = word;
      c.key  = key;
      cmd_backlog.push_back(c);
      if (op == OP_ENQ && plan_words.size() < DEPTH) begin
         plan_words.push_back(word);
      end else if (op == OP_DEQ && plan_words.size() != 0) begin
         void'(plan_words.pop_front());
      end
   endtask

   function automatic logic [VALUE_W-1:0] pick_word();
      int r;
      logic [VALUE_W-1:0] w;
      r = $urandom_range(99);
      if (r < 40) begin
         w = VALUE_W'($urandom_range(7));
      end else if (r < 50) begin
         case ($urandom_range(3))
            0: w = 32'h8000_0000;
            1: w = 32'h7fff_ffff;
            2: w = 32'hffff_ffff;
            default: w = '0;
         endcase
      end else begin
         w = $urandom;
      end
      return w;
   endfunction

   task automatic load_random(int n);
      int enq_bias;
      int r;
      logic [VALUE_W-1:0] k;
      enq_bias = 50;
      for (int i = 0; i < n; i++) begin
         if (i % 20 == 0) begin
            case ($urandom_range(2))
               0: enq_bias = 15;
               1: enq_bias = 50;
               default: enq_bias = 85;
            endcase
         end
         r = $urandom_range(99);
         if (r < 3) begin
            add_cmd(OP_UNUSED, $urandom, $urandom);
         end else if (r < 30) begin
            if (plan_words.size() != 0 && $urandom_range(99) < 65) begin
               k = plan_words[$urandom_range(plan_words.size() - 1)];
            end else begin
               k = pick_word();
            end
            add_cmd(OP_SEARCH, $urandom, k);
         end else if ($urandom_range(99) < enq_bias) begin
            add_cmd(OP_ENQ, pick_word(), $urandom);
         end else begin
            add_cmd(OP_DEQ, $urandom, $urandom);
         end
      end
   endtask

   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_valid || pending_outcomes.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      send_idle_pct = 15;
      recv_idle_pct = 68;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_cmd(OP_DEQ, $urandom, $urandom);
      add_cmd(OP_SEARCH, $urandom, '0);
      add_cmd(OP_UNUSED, $urandom, $urandom);
      add_cmd(OP_ENQ, 32'h8000_0000, '0);
      add_cmd(OP_ENQ, 32'h7fff_ffff, '1);
      add_cmd(OP_ENQ, 32'hffff_ffff, '0);
      add_cmd(OP_ENQ, 32'h0000_0000, '1);
      for (int i = 0; i < 12; i++) begin
         add_cmd(OP_ENQ, VALUE_W'(i % 4), $urandom);
      end
      add_cmd(OP_ENQ, 32'h1234_5678, '0);
      add_cmd(OP_SEARCH, '0, 32'h8000_0000);
      add_cmd(OP_SEARCH, '1, 32'h0000_0001);
      add_cmd(OP_SEARCH, '0, 32'h5555_aaaa);
      add_cmd(OP_DEQ, '1, '1);
      add_cmd(OP_UNUSED, '1, '1);
      wait_drained();

      load_random(250);
      wait_drained();

      send_idle_pct = 68;
      recv_idle_pct = 15;
      load_random(250);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_random(250);
      wait_drained();

      repeat (40) @(negedge clock);
      if (mismatch_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/fqs_pkg.sv
src/fqs_ctrl.sv
src/fqs_datapath.sv
src/fifo_queue_with_search_unit.sv
test/fifo_queue_with_search_unit_tb.sv
